FILE: design/prg_pkg.sv
// prg_pkg: shared types and constants of the parameter ramp generator
// sequencer states, curve codes, register indexes and fixed Q0.16 constants
// used by parameter_ramp_generator_unit; depends on nothing
package prg_pkg;

  // register indexes on the configuration channel
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START   = 3'd0,
    REG_GOAL    = 3'd1,
    REG_LENGTH  = 3'd2,
    REG_CURVE   = 3'd3,
    REG_RAMP_EN = 3'd4,
    REG_MOD_EN  = 3'd5
  } cfg_reg_e;

  // curve codes; the unused code falls back to linear
  localparam int CURVE_BITS = 2;

  typedef enum logic [CURVE_BITS-1:0] {
    CURVE_LINEAR = 2'd0,
    CURVE_EXP    = 2'd1,
    CURVE_LOG    = 2'd2
  } curve_e;

  // Q0.16 fractions carried with one integer bit so that 1.0 fits
  localparam int FRAC_BITS = 16;
  localparam int QW        = FRAC_BITS + 1;

  localparam logic [QW-1:0] Q16_ONE  = 17'h10000;
  localparam logic [QW-1:0] COEF_LIN = 17'd629;
  localparam logic [QW-1:0] COEF_SQ  = 17'd1163;
  // ceil(2^19 / 7), quotient may come out one high and is corrected after
  localparam logic [QW-1:0] REC7     = 17'd74899;

  // long division makes one quotient bit per cycle
  localparam int DIV_CNT_BITS = 4;
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = 4'd15;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_SQ,
    ST_CUBE,
    ST_QUINT,
    ST_LIN1,
    ST_REC1,
    ST_FIX1,
    ST_REC2,
    ST_FIX2,
    ST_SUB,
    ST_POLY,
    ST_SCALE,
    ST_ACC,
    ST_MODM,
    ST_MODA,
    ST_MODS,
    ST_OUT
  } state_e;

endpackage

FILE: design/parameter_ramp_generator_unit.sv
// parameter_ramp_generator_unit: one ramped Q16.16 level per sample beat
// iterative long divider plus one shared multiplier under a small sequencer
// depends on prg_pkg
//
//  channel | signals                                     | dir | purpose
//  --------+---------------------------------------------+-----+--------------------------
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i| in  | register writes
//  in      | in_valid_i in_ready_o mod_value_i           | in  | one modulator beat/tick
//  out     | out_valid_o out_ready_i level_o ramp_done_o | out | one level beat/tick
//
// a disabled or finished ramp skips the divider; a running ramp passes the
// 16-step divider, and the exp and log curves then a chain of
// products through the one multiplier; modulation steps through each 16-bit
// digit of the modulator. reset clears the config registers and the ramp.
// the input is taken while a finished level still waits in the output register.
// config and input are taken only while the sequencer is idle, config first.
module parameter_ramp_generator_unit #(
  parameter int LENGTH_BITS = 24,
  parameter int VALUE_BITS  = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [prg_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [((VALUE_BITS > LENGTH_BITS) ? VALUE_BITS : LENGTH_BITS)-1:0] cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [VALUE_BITS-1:0]          mod_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [VALUE_BITS-1:0]          level_o,
  output logic                                  ramp_done_o
);

  localparam int QW     = prg_pkg::QW;
  localparam int MulA   = (VALUE_BITS + 1 > 19) ? VALUE_BITS + 1 : 19;
  localparam int ProdW  = MulA + QW;
  localparam int NumDig = (VALUE_BITS + 15) / 16;
  localparam int DigW   = (NumDig > 1) ? $clog2(NumDig) : 1;
  localparam int AccW   = 2 * VALUE_BITS;
  localparam int QuoW   = AccW - 16;

  localparam logic [VALUE_BITS-1:0] VMax = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VMin = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [QuoW-1:0] QLim = {{(QuoW-1){1'b0}}, 1'b1} << (VALUE_BITS - 1);
  localparam logic [DigW-1:0] DigTop = DigW'(NumDig - 1);

  // configuration registers
  logic signed [VALUE_BITS-1:0]  start_q, goal_q;
  logic [LENGTH_BITS-1:0]        len_q;
  logic [prg_pkg::CURVE_BITS-1:0] curve_q;
  logic                          ramp_en_q, mod_en_q;

  // ramp state
  logic [LENGTH_BITS-1:0] pos_q;
  logic                   reached_q;

  prg_pkg::state_e state_q, state_d;

  // working registers
  logic signed [VALUE_BITS-1:0] base_q, oth_q, mod_q, lvl_q;
  logic                         done_q;
  logic [LENGTH_BITS-1:0]       rem_q;
  logic [15:0]                  quo_q;
  logic [prg_pkg::DIV_CNT_BITS-1:0] cnt_q;
  logic [QW-1:0]                m_q, m2_q, m3_q, d_q, f_q, p_q;
  logic [18:0]                  t_q;
  logic [ProdW-1:0]             prod_q;
  logic [AccW-1:0]              acc_q;
  logic [DigW-1:0]              dig_q;

  // output register
  logic                         out_valid_q;
  logic signed [VALUE_BITS-1:0] level_out_q;
  logic                         done_out_q;

  // handshakes and shared multiplier operands
  logic             in_fire, cfg_fire, out_load, cfg_known;
  logic [MulA-1:0]  mul_a;
  logic [QW-1:0]    mul_b;

  // accept-time decision
  logic                   ended, is_linear, is_exp;
  logic [LENGTH_BITS-1:0] pos_inc;

  // datapath helpers
  logic [LENGTH_BITS:0]      div_sh;
  logic                      div_bit;
  logic [QW-1:0]             prod_hi, quo_ext;
  logic [18:0]               prod_t;
  logic [QW-1:0]             rec_q0, rec_fix;
  logic [19:0]               rec_x7;
  logic [17:0]               poly_sub;
  logic signed [VALUE_BITS:0] diff;
  logic                      diff_neg;
  logic [VALUE_BITS:0]       diff_mag, scale_r;
  logic [VALUE_BITS+1:0]     scale_sum;
  logic [VALUE_BITS-1:0]     scale_sat;
  logic [VALUE_BITS-1:0]     lvl_mag, mod_mag;
  logic [NumDig*16-1:0]      mod_pad;
  logic [15:0]               mod_dig;
  logic                      mod_neg;
  logic [QuoW-1:0]           mod_quo;
  logic [VALUE_BITS-1:0]     mod_res;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  assign cfg_known = (cfg_index_i == prg_pkg::REG_START)   ||
                     (cfg_index_i == prg_pkg::REG_GOAL)    ||
                     (cfg_index_i == prg_pkg::REG_LENGTH)  ||
                     (cfg_index_i == prg_pkg::REG_CURVE)   ||
                     (cfg_index_i == prg_pkg::REG_RAMP_EN) ||
                     (cfg_index_i == prg_pkg::REG_MOD_EN);

  assign ended     = reached_q || (len_q == '0) || (pos_q >= len_q);
  assign pos_inc   = pos_q + LENGTH_BITS'(1);
  assign is_exp    = (curve_q == prg_pkg::CURVE_EXP);
  assign is_linear = (curve_q != prg_pkg::CURVE_EXP) && (curve_q != prg_pkg::CURVE_LOG);

  // one restoring division step: remainder stays below the length
  assign div_sh  = {rem_q, 1'b0};
  assign div_bit = (div_sh >= {1'b0, len_q});

  assign quo_ext = {1'b0, quo_q};
  assign prod_hi = prod_q[32:16];
  assign prod_t  = prod_q[26:8];

  // divide by 7 through the reciprocal, at most one high
  assign rec_q0  = prod_q[35:19];
  assign rec_x7  = ({3'b000, rec_q0} << 3) - {3'b000, rec_q0};
  assign rec_fix = (rec_x7 > {1'b0, t_q}) ? rec_q0 - QW'(1) : rec_q0;

  assign poly_sub = prod_q[33:16];

  assign diff     = {oth_q[VALUE_BITS-1], oth_q} - {base_q[VALUE_BITS-1], base_q};
  assign diff_neg = diff[VALUE_BITS];
  assign diff_mag = diff_neg ? (VALUE_BITS+1)'(0) - diff : diff;

  assign scale_r   = prod_q[16 +: VALUE_BITS+1];
  assign scale_sum = {{2{base_q[VALUE_BITS-1]}}, base_q} +
                     (diff_neg ? (VALUE_BITS+2)'(0) - {1'b0, scale_r} : {1'b0, scale_r});

  always_comb begin
    if ((scale_sum[VALUE_BITS+1:VALUE_BITS-1] == 3'b000) ||
        (scale_sum[VALUE_BITS+1:VALUE_BITS-1] == 3'b111)) begin
      scale_sat = scale_sum[VALUE_BITS-1:0];
    end else if (scale_sum[VALUE_BITS+1]) begin
      scale_sat = VMin;
    end else begin
      scale_sat = VMax;
    end
  end

  // modulation works on magnitudes, digits of the modulator from the top
  assign lvl_mag = lvl_q[VALUE_BITS-1] ? VALUE_BITS'(0) - lvl_q : lvl_q;
  assign mod_mag = mod_q[VALUE_BITS-1] ? VALUE_BITS'(0) - mod_q : mod_q;
  assign mod_pad = (NumDig*16)'(mod_mag);
  assign mod_dig = mod_pad[dig_q*16 +: 16];
  assign mod_neg = lvl_q[VALUE_BITS-1] ^ mod_q[VALUE_BITS-1];
  assign mod_quo = acc_q[AccW-1:16];

  always_comb begin
    if (mod_quo > QLim) begin
      mod_res = mod_neg ? VMin : VMax;
    end else if (mod_neg) begin
      mod_res = VALUE_BITS'(0) - mod_quo[VALUE_BITS-1:0];
    end else if (mod_quo[VALUE_BITS-1]) begin
      mod_res = VMax;
    end else begin
      mod_res = mod_quo[VALUE_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prg_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (ramp_en_q && !ended) begin
            state_d = prg_pkg::ST_DIV;
          end else if (mod_en_q) begin
            state_d = prg_pkg::ST_MODM;
          end else begin
            state_d = prg_pkg::ST_OUT;
          end
        end
      end
      prg_pkg::ST_DIV: begin
        if (cnt_q == prg_pkg::DIV_LAST) state_d = prg_pkg::ST_PREP;
      end
      prg_pkg::ST_PREP:  state_d = is_linear ? prg_pkg::ST_SCALE : prg_pkg::ST_SQ;
      prg_pkg::ST_SQ:    state_d = prg_pkg::ST_CUBE;
      prg_pkg::ST_CUBE:  state_d = prg_pkg::ST_QUINT;
      prg_pkg::ST_QUINT: state_d = prg_pkg::ST_LIN1;
      prg_pkg::ST_LIN1:  state_d = prg_pkg::ST_REC1;
      prg_pkg::ST_REC1:  state_d = prg_pkg::ST_FIX1;
      prg_pkg::ST_FIX1:  state_d = prg_pkg::ST_REC2;
      prg_pkg::ST_REC2:  state_d = prg_pkg::ST_FIX2;
      prg_pkg::ST_FIX2:  state_d = prg_pkg::ST_SUB;
      prg_pkg::ST_SUB:   state_d = prg_pkg::ST_POLY;
      prg_pkg::ST_POLY:  state_d = prg_pkg::ST_SCALE;
      prg_pkg::ST_SCALE: state_d = prg_pkg::ST_ACC;
      prg_pkg::ST_ACC:   state_d = mod_en_q ? prg_pkg::ST_MODM : prg_pkg::ST_OUT;
      prg_pkg::ST_MODM:  state_d = prg_pkg::ST_MODA;
      prg_pkg::ST_MODA:  state_d = (dig_q == '0) ? prg_pkg::ST_MODS : prg_pkg::ST_MODM;
      prg_pkg::ST_MODS:  state_d = prg_pkg::ST_OUT;
      prg_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = prg_pkg::ST_IDLE;
      end
      default: state_d = prg_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshakes and multiplier operand selection
  always_comb begin
    cfg_ready_o = (state_q == prg_pkg::ST_IDLE);
    in_ready_o  = (state_q == prg_pkg::ST_IDLE) && !cfg_valid_i;
    out_load    = (state_q == prg_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_q)
      prg_pkg::ST_SQ: begin
        mul_a = MulA'(m_q);
        mul_b = m_q;
      end
      prg_pkg::ST_CUBE: begin
        mul_a = MulA'(prod_hi);
        mul_b = m_q;
      end
      prg_pkg::ST_QUINT: begin
        mul_a = MulA'(prod_hi);
        mul_b = m2_q;
      end
      prg_pkg::ST_LIN1: begin
        mul_a = MulA'(m_q);
        mul_b = prg_pkg::COEF_LIN;
      end
      prg_pkg::ST_REC1, prg_pkg::ST_REC2: begin
        mul_a = MulA'(prod_t);
        mul_b = prg_pkg::REC7;
      end
      prg_pkg::ST_FIX1: begin
        mul_a = MulA'(m2_q);
        mul_b = prg_pkg::COEF_SQ;
      end
      prg_pkg::ST_SUB: begin
        mul_a = MulA'(d_q);
        mul_b = p_q;
      end
      prg_pkg::ST_SCALE: begin
        mul_a = MulA'(diff_mag);
        mul_b = f_q;
      end
      prg_pkg::ST_MODM: begin
        mul_a = MulA'(lvl_mag);
        mul_b = {1'b0, mod_dig};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prg_pkg::ST_IDLE;
      start_q     <= '0;
      goal_q      <= '0;
      len_q       <= '0;
      curve_q     <= '0;
      ramp_en_q   <= 1'b0;
      mod_en_q    <= 1'b0;
      pos_q       <= '0;
      reached_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          prg_pkg::REG_START:   start_q   <= cfg_data_i[VALUE_BITS-1:0];
          prg_pkg::REG_GOAL:    goal_q    <= cfg_data_i[VALUE_BITS-1:0];
          prg_pkg::REG_LENGTH:  len_q     <= cfg_data_i[LENGTH_BITS-1:0];
          prg_pkg::REG_CURVE:   curve_q   <= cfg_data_i[prg_pkg::CURVE_BITS-1:0];
          prg_pkg::REG_RAMP_EN: ramp_en_q <= cfg_data_i[0];
          prg_pkg::REG_MOD_EN:  mod_en_q  <= cfg_data_i[0];
          default: ;
        endcase
        // any known register write restarts the ramp
        if (cfg_known) begin
          pos_q     <= '0;
          reached_q <= 1'b0;
        end
      end else if (in_fire && ramp_en_q) begin
        if (ended) begin
          reached_q <= 1'b1;
        end else begin
          pos_q     <= pos_inc;
          reached_q <= (pos_inc >= len_q);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    unique case (state_q)
      prg_pkg::ST_IDLE: begin
        if (in_fire) begin
          mod_q  <= mod_value_i;
          acc_q  <= '0;
          dig_q  <= DigTop;
          rem_q  <= pos_q;
          quo_q  <= '0;
          cnt_q  <= '0;
          base_q <= is_exp ? goal_q : start_q;
          oth_q  <= is_exp ? start_q : goal_q;
          if (!ramp_en_q) begin
            lvl_q  <= start_q;
            done_q <= 1'b0;
          end else if (ended) begin
            lvl_q  <= goal_q;
            done_q <= 1'b1;
          end else begin
            done_q <= 1'b0;
          end
        end
      end
      prg_pkg::ST_DIV: begin
        rem_q <= div_bit ? LENGTH_BITS'(div_sh - {1'b0, len_q}) : LENGTH_BITS'(div_sh);
        quo_q <= {quo_q[14:0], div_bit};
        cnt_q <= cnt_q + prg_pkg::DIV_CNT_BITS'(1);
      end
      prg_pkg::ST_PREP: begin
        f_q <= quo_ext;
        m_q <= is_exp ? prg_pkg::Q16_ONE - quo_ext : quo_ext;
      end
      prg_pkg::ST_CUBE:  m2_q <= prod_hi;
      prg_pkg::ST_QUINT: m3_q <= prod_hi;
      prg_pkg::ST_LIN1:  d_q  <= (m2_q > prod_hi) ? m2_q - prod_hi : '0;
      prg_pkg::ST_REC1:  t_q  <= prod_t;
      prg_pkg::ST_FIX1:  p_q  <= rec_fix;
      prg_pkg::ST_REC2:  t_q  <= prod_t;
      prg_pkg::ST_FIX2:  p_q  <= p_q + rec_fix;
      prg_pkg::ST_POLY: begin
        f_q <= ({1'b0, m3_q} > poly_sub) ? QW'({1'b0, m3_q} - poly_sub) : '0;
      end
      prg_pkg::ST_ACC:   lvl_q <= scale_sat;
      prg_pkg::ST_MODA: begin
        acc_q <= (acc_q << 16) + AccW'(prod_q);
        dig_q <= dig_q - DigW'(1);
      end
      prg_pkg::ST_MODS:  lvl_q <= mod_res;
      default: ;
    endcase
    if (out_load) begin
      level_out_q <= lvl_q;
      done_out_q  <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_out_q;
  assign ramp_done_o = done_out_q;

  // divider remainder never reaches the length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prg_pkg::ST_DIV) |-> (rem_q < len_q))
    else $error("divider remainder not below ramp length");

  // a finished ramp sits at or past its length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reached_q |-> (pos_q >= len_q))
    else $error("goal flag set with ramp position short of length");

  // an accepted beat always starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != prg_pkg::ST_IDLE))
    else $error("accepted beat left sequencer idle");

  // curve factor never exceeds one when scaling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == prg_pkg::ST_SCALE) |-> (f_q <= prg_pkg::Q16_ONE))
    else $error("curve factor above one");

endmodule
